@@ hw/rtl/lrd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_pkg: shared types and constants of the replay detector
// Field widths, register map, control bundles between the top level and cells.
// ----------------------------------------------------------------------------
package lrd_pkg;

	// record and alert field widths
	localparam int STATUS_W  = 8;
	localparam int MTYPE_W   = 3;
	localparam int ADDR_W    = 32;
	localparam int COUNTER_W = 16;
	localparam int TIME_W    = 64;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;

	// register reset values
	localparam logic [STATUS_W-1:0] ACCEPTED_STATUS_RST = 8'd16;
	localparam logic [MTYPE_W-1:0]  TYPE_MIN_RST        = 3'd2;
	localparam logic [MTYPE_W-1:0]  TYPE_MAX_RST        = 3'd5;

	// default device table size
	localparam int TABLE_ENTRIES_DEF = 256;

	// reduction tree fan-in is 2**LOG2_FAN
	localparam int LOG2_FAN = 4;

	// register index codes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ACCEPTED_STATUS = 2'd0,
		REG_TYPE_MIN        = 2'd1,
		REG_TYPE_MAX        = 2'd2,
		REG_UNUSED          = 2'd3
	} lrd_reg_t;

	// lookup key broadcast to every cell
	typedef struct packed {
		logic [ADDR_W-1:0]    addr;
		logic [COUNTER_W-1:0] counter;
	} lrd_query_t;

	// sequencing strobes to every cell
	typedef struct packed {
		logic cmp_en;   // register match and alert flags
		logic upd_en;   // apply the table update
		logic hit_any;  // some cell matched the address
	} lrd_cell_ctl_t;

endpackage : lrd_pkg
`default_nettype wire

@@ hw/rtl/lrd_rec_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_rec_if: captured uplink record channel
// Valid/ready handshake carrying one record per request.
// ----------------------------------------------------------------------------
interface lrd_rec_if;
	logic                           valid;
	logic                           ready;
	logic [lrd_pkg::STATUS_W-1:0]   record_status;
	logic [lrd_pkg::MTYPE_W-1:0]    message_type;
	logic [lrd_pkg::ADDR_W-1:0]     device_address;
	logic [lrd_pkg::COUNTER_W-1:0]  frame_counter;
	logic [lrd_pkg::TIME_W-1:0]     capture_time;

	modport source (
		output valid, record_status, message_type, device_address,
		       frame_counter, capture_time,
		input  ready
	);
	modport sink (
		input  valid, record_status, message_type, device_address,
		       frame_counter, capture_time,
		output ready
	);
endinterface : lrd_rec_if
`default_nettype wire

@@ hw/rtl/lrd_alert_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_alert_if: replay alert channel
// Valid/ready handshake carrying one alert per request.
// ----------------------------------------------------------------------------
interface lrd_alert_if;
	logic                           valid;
	logic                           ready;
	logic [lrd_pkg::ADDR_W-1:0]     incident_address;
	logic [lrd_pkg::TIME_W-1:0]     alert_time;
	logic [lrd_pkg::COUNTER_W-1:0]  replayed_counter;

	modport source (
		output valid, incident_address, alert_time, replayed_counter,
		input  ready
	);
	modport sink (
		input  valid, incident_address, alert_time, replayed_counter,
		output ready
	);
endinterface : lrd_alert_if
`default_nettype wire

@@ hw/rtl/lrd_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_cell: one device table entry
// Holds address, last counter and restart mark; compares against the
// broadcast key and applies hit updates or in-order inserts. The valid bit
// is handed to the next cell so the first empty cell takes an insert.
// ----------------------------------------------------------------------------
module lrd_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lrd_pkg::lrd_query_t   query,
	input  wire lrd_pkg::lrd_cell_ctl_t ctl,
	input  wire logic                  prev_valid,
	output logic                       valid,
	output logic                       hit_s1,
	output logic                       alert_s1
);
	import lrd_pkg::*;

	logic                 valid_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [COUNTER_W-1:0] last_q;
	logic                 mark_q;
	logic                 match;
	logic                 cnt_zero;
	logic                 take_insert;

	assign valid       = valid_q;
	assign match       = valid_q && (addr_q == query.addr);
	assign cnt_zero    = (query.counter == '0);
	// first empty cell in the row
	assign take_insert = !ctl.hit_any && !valid_q && prev_valid;

	// compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1   <= 1'b0;
			alert_s1 <= 1'b0;
		end else if (ctl.cmp_en) begin
			hit_s1   <= match;
			alert_s1 <= match && mark_q && !cnt_zero && (last_q == query.counter);
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.upd_en && take_insert) begin
			valid_q <= 1'b1;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			priority if (hit_s1) begin
				mark_q <= cnt_zero;
				if (!cnt_zero) begin
					last_q <= query.counter;
				end
			end else if (take_insert) begin
				addr_q <= query.addr;
				last_q <= query.counter;
				mark_q <= 1'b0;
			end
		end
	end

endmodule : lrd_cell
`default_nettype wire

@@ hw/rtl/lrd_or_tree.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lrd_or_tree: registered OR reduction over the cell row
// One register level per 2**LOG2_FAN-way OR.
// ----------------------------------------------------------------------------
module lrd_or_tree #(
	parameter int N = lrd_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic         clk,
	input  wire logic [N-1:0] bits_in,
	output logic              any_out
);
	import lrd_pkg::*;

	localparam int LEVELS = ($clog2(N) + LOG2_FAN - 1) / LOG2_FAN;
	localparam int FAN    = 1 << LOG2_FAN;
	localparam int W      = 1 << (LEVELS * LOG2_FAN);

	logic [W-1:0] lv [1:LEVELS];

	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		logic [W-1:0] src;

		// first level reads the zero-padded cell row
		if (k == 0) begin : g_first
			assign src = W'(bits_in);
		end else begin : g_next
			assign src = lv[k];
		end

		// each level folds groups of FAN bits into one
		always_ff @(posedge clk) begin
			for (int j = 0; j < W / FAN; j++) begin
				lv[k+1][j] <= |src[j*FAN +: FAN];
			end
			lv[k+1][W-1:W/FAN] <= '0;
		end
	end

	assign any_out = lv[LEVELS][0];

endmodule : lrd_or_tree
`default_nettype wire

@@ hw/rtl/lorawan_replay_detector_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lorawan_replay_detector_top: replay detector for captured uplinks
// Filters records, looks the device up in a row of table cells and raises an
// alert when a counter seen before a restart is sent again.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  rec     | in  | valid/ready         | status, type, address, counter, time
//  alert   | out | valid/ready         | address, time, replayed counter
//  apb     | in  | psel/penable/pready | 3 registers at 0x0, 0x4, 0x8
//
//  A filtered-out record is taken and dropped in the idle state. An examined
//  record goes through accept, a compare step in all cells, the registered
//  OR tree, whose depth is LEVELS, and an update step.
//  LEVELS = ceil(log2(TABLE_ENTRIES)/4).
//  An update that raises an alert waits while an earlier alert is still held
//  on the output and not taken.
//  Reset clears all valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module lorawan_replay_detector_top #(
	parameter int TABLE_ENTRIES = lrd_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lrd_rec_if.sink                          rec,
	lrd_alert_if.source                      alert,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lrd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lrd_pkg::PDATA_W-1:0] pwdata,
	output logic      [lrd_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import lrd_pkg::*;

	localparam int LEVELS = ($clog2(TABLE_ENTRIES) + LOG2_FAN - 1) / LOG2_FAN;
	localparam int LVL_W  = $clog2(LEVELS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [LVL_W-1:0]     wait_q;
	logic [STATUS_W-1:0]  acc_status_q;
	logic [MTYPE_W-1:0]   type_min_q;
	logic [MTYPE_W-1:0]   type_max_q;
	logic [ADDR_W-1:0]    key_addr_q;
	logic [COUNTER_W-1:0] key_cnt_q;
	logic [TIME_W-1:0]    key_time_q;
	logic                 out_valid_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [TIME_W-1:0]    out_time_q;
	logic [COUNTER_W-1:0] out_cnt_q;

	logic                 rec_fire;
	logic                 examine;
	logic                 upd_fire;
	logic                 hit_any;
	logic                 alert_any;
	logic                 cfg_wr;
	lrd_reg_t             reg_idx;
	lrd_query_t           query;
	lrd_cell_ctl_t        ctl;
	logic [TABLE_ENTRIES-1:0] valid_v;
	logic [TABLE_ENTRIES-1:0] hit_v;
	logic [TABLE_ENTRIES-1:0] alert_v;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = lrd_reg_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_status_q <= ACCEPTED_STATUS_RST;
			type_min_q   <= TYPE_MIN_RST;
			type_max_q   <= TYPE_MAX_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ACCEPTED_STATUS: acc_status_q <= pwdata[STATUS_W-1:0];
				REG_TYPE_MIN:        type_min_q   <= pwdata[MTYPE_W-1:0];
				REG_TYPE_MAX:        type_max_q   <= pwdata[MTYPE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ACCEPTED_STATUS: prdata = {{(PDATA_W-STATUS_W){1'b0}}, acc_status_q};
			REG_TYPE_MIN:        prdata = {{(PDATA_W-MTYPE_W){1'b0}}, type_min_q};
			REG_TYPE_MAX:        prdata = {{(PDATA_W-MTYPE_W){1'b0}}, type_max_q};
			default:             prdata = '0;
		endcase
	end

	// record filter
	assign rec.ready = (state_q == ST_IDLE);
	assign rec_fire  = rec.valid && rec.ready;
	assign examine   = (rec.record_status == acc_status_q) &&
	                   (rec.device_address != '0) &&
	                   (rec.message_type >= type_min_q) &&
	                   (rec.message_type <= type_max_q);

	// lookup key
	always_ff @(posedge clk) begin
		if (rec_fire) begin
			key_addr_q <= rec.device_address;
			key_cnt_q  <= rec.frame_counter;
			key_time_q <= rec.capture_time;
		end
	end

	// an update with an alert needs a free output register
	assign upd_fire = (state_q == ST_UPD) && (!alert_any || !out_valid_q || alert.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rec_fire && examine) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_WAIT;
					wait_q  <= LVL_W'(LEVELS - 1);
				end
				ST_WAIT: begin
					if (wait_q == '0) begin
						state_q <= ST_UPD;
					end else begin
						wait_q <= wait_q - 1'b1;
					end
				end
				ST_UPD: begin
					if (upd_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// cell row
	assign query.addr    = key_addr_q;
	assign query.counter = key_cnt_q;
	assign ctl.cmp_en    = (state_q == ST_CMP);
	assign ctl.upd_en    = upd_fire;
	assign ctl.hit_any   = hit_any;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		lrd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.query      (query),
			.ctl        (ctl),
			.prev_valid ((i == 0) ? 1'b1 : valid_v[(i == 0) ? 0 : i-1]),
			.valid      (valid_v[i]),
			.hit_s1     (hit_v[i]),
			.alert_s1   (alert_v[i])
		);
	end

	// hit and alert reduction
	lrd_or_tree #(.N(TABLE_ENTRIES)) u_hit_tree (
		.clk     (clk),
		.bits_in (hit_v),
		.any_out (hit_any)
	);

	lrd_or_tree #(.N(TABLE_ENTRIES)) u_alert_tree (
		.clk     (clk),
		.bits_in (alert_v),
		.any_out (alert_any)
	);

	// alert output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire && alert_any) begin
			out_valid_q <= 1'b1;
		end else if (alert.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire && alert_any) begin
			out_addr_q <= key_addr_q;
			out_time_q <= key_time_q;
			out_cnt_q  <= key_cnt_q;
		end
	end

	assign alert.valid            = out_valid_q;
	assign alert.incident_address = out_addr_q;
	assign alert.alert_time       = out_time_q;
	assign alert.replayed_counter = out_cnt_q;

	// checks
	a_alert_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) && alert_any |-> hit_any)
		else $error("alert without a table hit");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> $onehot0(hit_v))
		else $error("device address stored in more than one cell");

	a_fill_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_v[TABLE_ENTRIES-1:1] & ~valid_v[TABLE_ENTRIES-2:0]) == '0)
		else $error("table cells not filled in order");

	a_accept_examine: assert property (@(posedge clk) disable iff (!arst_n)
		rec_fire && examine |=> (state_q == ST_CMP))
		else $error("examined record did not start a lookup");

endmodule : lorawan_replay_detector_top
`default_nettype wire

@@ tb/sv/lrd_replay_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrd_replay_checker: scoreboard for the uplink replay detector
// Watches the record, alert and register channels, keeps its own device table
// and filter settings, predicts every alert and compares each delivered alert
// field by field against the oldest one owed.
// ----------------------------------------------------------------------------
module lrd_replay_checker #(
	parameter int TABLE_ENTRIES = lrd_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lrd_rec_if                               rec,
	lrd_alert_if                             alert,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [lrd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lrd_pkg::PDATA_W-1:0] pwdata,
	output int                               fail_count,
	output int                               pending,
	output int                               alerts_seen
);
	import lrd_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0]    addr;
		logic [TIME_W-1:0]    stamp;
		logic [COUNTER_W-1:0] counter;
	} replay_alert_t;

	// filter settings as last written
	logic [STATUS_W-1:0] want_status;
	logic [MTYPE_W-1:0]  type_lo;
	logic [MTYPE_W-1:0]  type_hi;

	// device table, filled in order
	logic [ADDR_W-1:0]    known_addr  [TABLE_ENTRIES];
	logic [COUNTER_W-1:0] dev_count   [TABLE_ENTRIES];
	logic                 dev_restart [TABLE_ENTRIES];
	int                   dev_fill;

	replay_alert_t alerts_owed[$];

	// filter, look up and update the table; returns 1 when a replay is flagged
	function automatic bit judge_uplink(
		input  logic [STATUS_W-1:0]  st,
		input  logic [MTYPE_W-1:0]   mt,
		input  logic [ADDR_W-1:0]    ad,
		input  logic [COUNTER_W-1:0] fc,
		input  logic [TIME_W-1:0]    ts,
		output replay_alert_t        raised
	);
		int slot;
		int i;
		bit fired;
		slot = -1;
		fired = 1'b0;
		raised = '0;
		if (st != want_status || ad == '0 || mt < type_lo || mt > type_hi)
			return 1'b0;
		for (i = 0; i < dev_fill; i++) begin
			if (slot < 0 && known_addr[i] == ad)
				slot = i;
		end
		if (slot < 0) begin
			// miss: append, or drop silently once the table is full
			if (dev_fill < TABLE_ENTRIES) begin
				known_addr[dev_fill]  = ad;
				dev_count[dev_fill]   = fc;
				dev_restart[dev_fill] = 1'b0;
				dev_fill++;
			end
			return 1'b0;
		end
		// hit: a nonzero counter resent right after a restart is a replay
		if (dev_restart[slot] && fc != '0 && dev_count[slot] == fc) begin
			raised = '{addr: ad, stamp: ts, counter: fc};
			fired = 1'b1;
		end
		dev_restart[slot] = 1'b0;
		if (fc != '0)
			dev_count[slot] = fc;
		else
			dev_restart[slot] = 1'b1;
		return fired;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: alert %s mismatch, expected %h, actual %h",
				$time, what, want, got);
			fail_count++;
		end
	endtask

	// sample every channel at the rising edge
	always @(posedge clk or negedge arst_n) begin : track
		replay_alert_t due;
		replay_alert_t raised;
		if (!arst_n) begin
			want_status = ACCEPTED_STATUS_RST;
			type_lo = TYPE_MIN_RST;
			type_hi = TYPE_MAX_RST;
			dev_fill = 0;
			alerts_owed.delete();
			pending = 0;
		end else begin
			// delivered alert against the oldest one owed
			if (alert.valid && alert.ready) begin
				alerts_seen++;
				if (alerts_owed.size() == 0) begin
					$display("%0t: alert with none expected, actual addr %h time %h counter %h",
						$time, alert.incident_address, alert.alert_time, alert.replayed_counter);
					fail_count++;
				end else begin
					due = alerts_owed.pop_front();
					check_field("incident_address", 64'(due.addr), 64'(alert.incident_address));
					check_field("alert_time", due.stamp, alert.alert_time);
					check_field("replayed_counter", 64'(due.counter),
						64'(alert.replayed_counter));
				end
			end
			// accepted record request
			if (rec.valid && rec.ready) begin
				if (judge_uplink(rec.record_status, rec.message_type, rec.device_address,
					rec.frame_counter, rec.capture_time, raised))
					alerts_owed.push_back(raised);
			end
			// register write
			if (psel && penable && pwrite && pready) begin
				case (lrd_reg_t'(paddr[PADDR_W-1:2]))
					REG_ACCEPTED_STATUS: want_status = pwdata[STATUS_W-1:0];
					REG_TYPE_MIN:        type_lo = pwdata[MTYPE_W-1:0];
					REG_TYPE_MAX:        type_hi = pwdata[MTYPE_W-1:0];
					default: ;
				endcase
			end
			pending = alerts_owed.size();
		end
	end

endmodule : lrd_replay_checker

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the uplink replay detector
// Drives directed and random record traffic in bursts through several filter
// settings, overflows the device table, stalls the alert side on its own
// pattern and leaves the checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module tb_top;
	import lrd_pkg::*;

	localparam int DEV_SLOTS     = TABLE_ENTRIES_DEF;
	localparam int POOL_SIZE     = 48;
	localparam int SETTLE_CYCLES = 12;
	localparam int IDLE_LIMIT    = 2000;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_BURSTY, SINK_THIRDS} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	lrd_rec_if   rec_ch ();
	lrd_alert_if alert_ch ();

	int fail_count;
	int pending;
	int alerts_seen;

	// stimulus-side view of the settings, used to shape records
	logic [STATUS_W-1:0] cfg_status = ACCEPTED_STATUS_RST;
	logic [MTYPE_W-1:0]  cfg_tmin = TYPE_MIN_RST;
	logic [MTYPE_W-1:0]  cfg_tmax = TYPE_MAX_RST;

	logic [ADDR_W-1:0] dev_pool [POOL_SIZE];
	int records_sent = 0;
	int noise_sent = 0;
	int fresh_count = 0;
	int burst_left = 1;

	sink_mode_t sink_mode = SINK_OPEN;
	int sink_hold = 0;
	int sink_tick = 0;

	always #1 clk = ~clk;

	lorawan_replay_detector_top #(.TABLE_ENTRIES(DEV_SLOTS)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec     (rec_ch),
		.alert   (alert_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lrd_replay_checker #(.TABLE_ENTRIES(DEV_SLOTS)) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (rec_ch),
		.alert       (alert_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.alerts_seen (alerts_seen)
	);

	function automatic logic [TIME_W-1:0] rand_stamp();
		return {$urandom, $urandom};
	endfunction

	// mostly random, with the counter extremes weighted in
	function automatic logic [COUNTER_W-1:0] pick_counter();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return 16'h0001;
			default: return COUNTER_W'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] fresh_addr();
		logic [ADDR_W-1:0] a;
		a = $urandom;
		if (a == '0)
			a = 32'h1;
		fresh_count++;
		return a;
	endfunction

	// one record request, then the sender's burst and gap pacing
	task automatic push_record(input logic [STATUS_W-1:0] st, input logic [MTYPE_W-1:0] mt,
		input logic [ADDR_W-1:0] ad, input logic [COUNTER_W-1:0] fc,
		input logic [TIME_W-1:0] ts);
		int gap;
		@(negedge clk);
		rec_ch.valid          <= 1'b1;
		rec_ch.record_status  <= st;
		rec_ch.message_type   <= mt;
		rec_ch.device_address <= ad;
		rec_ch.frame_counter  <= fc;
		rec_ch.capture_time   <= ts;
		@(posedge clk);
		while (!rec_ch.ready)
			@(posedge clk);
		records_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				@(negedge clk);
				rec_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// record that passes the current filter when the type range is not empty
	task automatic good_record(input logic [ADDR_W-1:0] ad, input logic [COUNTER_W-1:0] fc);
		logic [MTYPE_W-1:0] mt;
		if (cfg_tmin <= cfg_tmax)
			mt = MTYPE_W'($urandom_range(cfg_tmin, cfg_tmax));
		else
			mt = MTYPE_W'($urandom);
		push_record(cfg_status, mt, ad, fc, rand_stamp());
	endtask

	// record the filter should throw away, or a fully random one
	task automatic noise_record();
		logic [STATUS_W-1:0] st;
		logic [MTYPE_W-1:0] mt;
		logic [ADDR_W-1:0] ad;
		st = cfg_status;
		mt = MTYPE_W'($urandom);
		ad = $urandom;
		if (ad == '0)
			ad = 32'h1;
		case ($urandom_range(0, 3))
			0: st = cfg_status ^ STATUS_W'($urandom_range(1, 255));
			1: ad = '0;
			2: begin
				if (cfg_tmin > 0)
					mt = MTYPE_W'($urandom_range(0, cfg_tmin - 1));
				else if (cfg_tmax < 7)
					mt = MTYPE_W'($urandom_range(cfg_tmax + 1, 7));
				else
					st = ~cfg_status;
			end
			default: st = STATUS_W'($urandom);
		endcase
		noise_sent++;
		push_record(st, mt, ad, COUNTER_W'($urandom), rand_stamp());
	endtask

	// drop valid, wait out owed alerts and any record still in flight
	task automatic quiesce();
		@(negedge clk);
		rec_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input lrd_reg_t idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ACCEPTED_STATUS: cfg_status = val[STATUS_W-1:0];
			REG_TYPE_MIN:        cfg_tmin = val[MTYPE_W-1:0];
			REG_TYPE_MAX:        cfg_tmax = val[MTYPE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [STATUS_W-1:0] st, input logic [MTYPE_W-1:0] lo,
		input logic [MTYPE_W-1:0] hi);
		quiesce();
		apb_write(REG_ACCEPTED_STATUS, PDATA_W'(st));
		apb_write(REG_TYPE_MIN, PDATA_W'(lo));
		apb_write(REG_TYPE_MAX, PDATA_W'(hi));
	endtask

	// mostly restart-and-resend sequences, plus noise and lone records
	task automatic random_phase(input int goal);
		int done;
		int pick;
		logic [ADDR_W-1:0] ad;
		logic [COUNTER_W-1:0] c;
		done = 0;
		while (done < goal) begin
			pick = $urandom_range(0, 99);
			ad = dev_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (pick < 15) begin
				noise_record();
			end else if (pick < 70) begin
				// counter, restart, resend: a replay unless the resend differs
				if (pick < 30)
					ad = fresh_addr();
				c = pick_counter();
				good_record(ad, c);
				if ($urandom_range(0, 3) == 0)
					noise_record();
				good_record(ad, 16'h0);
				case ($urandom_range(0, 6))
					0: good_record(ad, c ^ COUNTER_W'($urandom_range(1, 65535)));
					1: good_record(ad, 16'h0);
					default: good_record(ad, c);
				endcase
				done += 3;
			end else begin
				good_record(ad, ($urandom_range(0, 4) == 0) ? 16'h0 : pick_counter());
				done++;
			end
			// now and then hold off until every owed alert is out
			if ($urandom_range(0, 149) == 0)
				quiesce();
		end
	endtask

	// alert side stalls on its own mode schedule
	always @(negedge clk) begin
		sink_tick++;
		if (sink_tick % 97 == 0)
			sink_mode = sink_mode_t'($urandom_range(0, 3));
		if (sink_hold > 0) begin
			sink_hold--;
			alert_ch.ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN: alert_ch.ready <= 1'b1;
				SINK_COIN: alert_ch.ready <= 1'($urandom_range(0, 1));
				SINK_BURSTY: begin
					alert_ch.ready <= 1'b1;
					if ($urandom_range(0, 5) == 0)
						sink_hold = $urandom_range(1, 24);
				end
				default: alert_ch.ready <= (sink_tick % 3 == 0);
			endcase
		end
	end

	// end the run when no request of any kind is accepted for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rec_ch.valid && rec_ch.ready) ||
				(alert_ch.valid && alert_ch.ready) || (psel && penable && pwrite && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog expired after %0d idle cycles, %0d alerts owed",
			$time, IDLE_LIMIT, pending);
		$display("lorawan_replay_detector_top regression: fail");
		$finish;
	end

	initial begin : stimulus
		logic [ADDR_W-1:0] dev_a;
		logic [ADDR_W-1:0] dev_b;
		int i;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rec_ch.valid = 1'b0;
		rec_ch.record_status = '0;
		rec_ch.message_type = '0;
		rec_ch.device_address = '0;
		rec_ch.frame_counter = '0;
		rec_ch.capture_time = '0;
		alert_ch.ready = 1'b0;
		for (i = 0; i < POOL_SIZE; i++) begin
			dev_pool[i] = $urandom;
			if (dev_pool[i] == '0)
				dev_pool[i] = 32'h2;
		end
		dev_a = '1;
		dev_b = 32'h1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: filter edges at the reset settings
		push_record(8'h00, 3'd3, dev_a, 16'h1234, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd3, '0, 16'h1234, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd1, dev_a, 16'h1234, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd6, dev_a, 16'h1234, rand_stamp());
		// insert, restart, replay, then the same counter again without a restart
		push_record(ACCEPTED_STATUS_RST, 3'd2, dev_a, '1, 64'h0);
		push_record(ACCEPTED_STATUS_RST, 3'd5, dev_a, 16'h0, '1);
		push_record(ACCEPTED_STATUS_RST, 3'd3, dev_a, '1, '1);
		push_record(ACCEPTED_STATUS_RST, 3'd4, dev_a, '1, 64'h0);
		// zero counter on insert, repeated zero counters
		push_record(ACCEPTED_STATUS_RST, 3'd2, dev_b, 16'h0, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd2, dev_b, 16'h0, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd2, dev_b, 16'h0, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd3, dev_b, 16'h1, rand_stamp());
		// restart then a different counter, then a true replay
		push_record(ACCEPTED_STATUS_RST, 3'd3, dev_b, 16'h0, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd3, dev_b, 16'h2, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd3, dev_b, 16'h0, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd3, dev_b, 16'h2, rand_stamp());
		// a filtered record between restart and resend leaves the mark alone
		push_record(ACCEPTED_STATUS_RST, 3'd3, dev_a, 16'h0, rand_stamp());
		push_record(8'd17, 3'd3, dev_a, '1, rand_stamp());
		push_record(ACCEPTED_STATUS_RST, 3'd3, dev_a, '1, rand_stamp());

		set_config(ACCEPTED_STATUS_RST, TYPE_MIN_RST, TYPE_MAX_RST);
		random_phase(150);

		// widest type range, all-ones status, unused register written once
		set_config('1, 3'd0, 3'd7);
		apb_write(REG_UNUSED, '1);
		random_phase(120);

		// overflow the table, then keep going with dropped devices
		while (fresh_count + POOL_SIZE + 2 < DEV_SLOTS + 16)
			good_record(fresh_addr(), pick_counter());
		random_phase(60);

		// empty type range: nothing is examined
		set_config(8'h00, 3'd7, 3'd0);
		random_phase(30);

		set_config(STATUS_W'($urandom_range(1, 254)), 3'd3, 3'd3);
		random_phase(150);

		set_config(STATUS_W'($urandom_range(1, 254)), 3'd0, 3'd0);
		random_phase(80);

		set_config(8'h00, 3'd7, 3'd7);
		random_phase(60);

		quiesce();
		$display("run covered %0d record requests (%0d filter noise), %0d alerts checked",
			records_sent, noise_sent, alerts_seen);
		$display("swept reset, 0x00/0xFF status, empty and single type ranges; %0d devs, %0d slots",
			fresh_count, DEV_SLOTS);
		if (fail_count == 0 && pending == 0)
			$display("lorawan_replay_detector_top regression: pass");
		else
			$display("lorawan_replay_detector_top regression: fail");
		$finish;
	end

endmodule : tb_top

@@ files.f @@
hw/rtl/lrd_pkg.sv
hw/rtl/lrd_rec_if.sv
hw/rtl/lrd_alert_if.sv
hw/rtl/lrd_cell.sv
hw/rtl/lrd_or_tree.sv
hw/rtl/lorawan_replay_detector_top.sv
tb/sv/lrd_replay_checker.sv
tb/sv/tb_top.sv
